// ===== rtl/zcs_pkg.sv =====
// shared types, constants and the arctangent table for the zadoff-chu generator
package zcs_pkg;

	localparam int LEN_W        = 12;
	localparam int MOD_W        = LEN_W + 1;
	localparam int AMP_W        = 15;
	localparam int ANGLE_W      = 16;
	localparam int SAMPLE_W     = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 15;

	localparam int MAX_LENGTH   = 4095;
	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_SIZE   = 24;
	localparam int ATAN_IDX_W   = $clog2(TABLE_SIZE);

	// divider passes: root mod length shifts in the root, the angle divide its 16 fraction bits
	localparam int REM_STEPS    = LEN_W;
	localparam int DIV_STEPS    = ANGLE_W;
	localparam int STEP_W       = $clog2((CORDIC_STEPS > DIV_STEPS) ? CORDIC_STEPS : DIV_STEPS);

	// cordic datapath: x0 = amplitude * gain stays below 2^31, growth 1.65 and the sign get three more bits
	localparam int GAIN_W       = 16;
	localparam int GAIN_Q16     = 39797;
	localparam int X0_W         = AMP_W + GAIN_W;
	localparam int CX_W         = X0_W + 3;
	localparam int CZ_W         = 32;

	localparam logic [LEN_W-1:0] RESET_LENGTH    = LEN_W'(401);
	localparam logic [LEN_W-1:0] RESET_ROOT      = LEN_W'(25);
	localparam logic [AMP_W-1:0] RESET_AMPLITUDE = AMP_W'(22938);
	localparam logic [MOD_W-1:0] RESET_STEP      = MOD_W'((2 * 25) % (2 * 401));

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LENGTH    = 2'd0,
		CFG_ROOT      = 2'd1,
		CFG_AMPLITUDE = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REM,
		ST_DIV,
		ST_LOAD,
		ST_CORDIC,
		ST_DONE
	} zcs_state_t;

	// arctangent of 2^-i, 2^32 per turn
	function automatic logic [CZ_W-1:0] atan_turns(input logic [ATAN_IDX_W-1:0] i);
		logic [CZ_W-1:0] v;
		unique case (i)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/zcs_cfg_if.sv =====
// configuration write channel: register index and write data
interface zcs_cfg_if;
	import zcs_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/zcs_in_if.sv =====
// sample request channel
interface zcs_in_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink   (input valid, input restart, output ready);
endinterface

// ===== rtl/zcs_out_if.sv =====
// sample result channel
interface zcs_out_if;
	import zcs_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] in_phase;
	logic signed [SAMPLE_W-1:0] quadrature;
	logic        [LEN_W-1:0]    sample_number;
	logic                       period_end;

	modport source (output valid, output in_phase, output quadrature, output sample_number,
		output period_end, input ready);
	modport sink   (input valid, input in_phase, input quadrature, input sample_number,
		input period_end, output ready);
endinterface

// ===== rtl/zadoff_chu_sequence_generator_unit.sv =====
// zadoff-chu sample generator: phase residue tracking, shared divider and iterative cordic
//
//  channel  dir  beat payload                                       handshake
//  cfg      in   index (2b), data (15b)                             valid/ready, ready always high
//  req      in   restart (1b)                                       valid/ready
//  rsp      out  in_phase, quadrature (16b s), sample_number (12b), valid/ready, output register
//                period_end (1b)
//
//  a request beat runs to its result through accept, 16 angle divide steps on the shared
//  restoring divider, angle load, 16 cordic micro-rotations, rotate/round once rsp is free
//  the next request may be taken the cycle after the result is loaded, even while rsp stalls
//  a write to length or root restarts the sequence and runs a root mod length pass on
//  the same divider, req.ready stays low during it; amplitude writes act at once
//  reset loads the default registers with the matching phase step, no pass after reset
module zadoff_chu_sequence_generator_unit (
	input  logic           clk,
	input  logic           arst_n,
	zcs_cfg_if.sink        cfg,
	zcs_in_if.sink         req,
	zcs_out_if.source      rsp
);
	import zcs_pkg::*;

	// configuration registers and derived phase step
	logic [LEN_W-1:0] cfg_len_q;
	logic [LEN_W-1:0] cfg_root_q;
	logic [AMP_W-1:0] cfg_amp_q;
	logic [MOD_W-1:0] r2_q;          // 2*root mod 2L
	logic             dirty_q;       // r2 must be recomputed

	// sequence state
	logic [LEN_W-1:0] n_q;
	logic [MOD_W-1:0] k_q;
	logic [MOD_W-1:0] d_q;

	// sequencer
	zcs_state_t       state_q, state_d;
	logic [STEP_W-1:0] step_q;

	// shared divider
	logic [MOD_W-1:0]   div_rem_q;
	logic [ANGLE_W-1:0] div_quo_q;
	logic [ANGLE_W-1:0] div_src_q;

	// cordic
	logic signed [CX_W-1:0] cx_q, cy_q;
	logic signed [CZ_W-1:0] cz_q;
	logic [1:0]             quad_q;
	logic [LEN_W-1:0]       samp_q;
	logic                   last_q;

	// output register
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_i_q, out_q_q;
	logic [LEN_W-1:0]           out_n_q;
	logic                       out_end_q;

	// effective length, clamped to [2, MAX_LENGTH], and modulus 2L
	logic [LEN_W-1:0] len_eff;
	logic [MOD_W-1:0] mod_c;

	always_comb begin
		if (cfg_len_q < LEN_W'(2)) begin
			len_eff = LEN_W'(2);
		end else if (cfg_len_q > LEN_W'(MAX_LENGTH)) begin
			len_eff = LEN_W'(MAX_LENGTH);
		end else begin
			len_eff = cfg_len_q;
		end
		mod_c = {len_eff, 1'b0};
	end

	// accept-time sequence update
	logic             accept;
	logic             restart_c;
	logic [LEN_W-1:0] n_e;
	logic [MOD_W-1:0] k_e, d_e;
	logic             last_c;
	logic [MOD_W:0]   k_sum, d_sum;
	logic [MOD_W-1:0] k_nx, d_nx;

	assign accept = req.valid && req.ready;

	always_comb begin
		restart_c = req.restart || (n_q >= len_eff) || (k_q >= mod_c) || (d_q >= mod_c);
		n_e = restart_c ? '0 : n_q;
		k_e = restart_c ? '0 : k_q;
		d_e = restart_c ? r2_q : d_q;
		last_c = (n_e == len_eff - LEN_W'(1));
		// both terms below 2L, one conditional subtract brings the sum back
		k_sum = {1'b0, k_e} + {1'b0, d_e};
		d_sum = {1'b0, d_e} + {1'b0, r2_q};
		k_nx = (k_sum >= {1'b0, mod_c}) ? MOD_W'(k_sum - {1'b0, mod_c}) : k_sum[MOD_W-1:0];
		d_nx = (d_sum >= {1'b0, mod_c}) ? MOD_W'(d_sum - {1'b0, mod_c}) : d_sum[MOD_W-1:0];
	end

	// restoring divider step, remainder always stays below the divisor
	logic [MOD_W-1:0] div_den;
	logic [MOD_W:0]   div_t;
	logic             div_ge;
	logic [MOD_W-1:0] div_rem_nx;

	always_comb begin
		div_den = (state_q == ST_REM) ? {1'b0, len_eff} : mod_c;
		div_t   = {div_rem_q, div_src_q[ANGLE_W-1]};
		div_ge  = (div_t >= {1'b0, div_den});
		div_rem_nx = div_ge ? MOD_W'(div_t - {1'b0, div_den}) : div_t[MOD_W-1:0];
	end

	// angle load: phase = -a turns, quadrant split, residual in [-1/8, 1/8) turn
	logic [ANGLE_W-1:0] neg_a;
	logic [ANGLE_W-1:0] quad_sum;
	logic [1:0]         quad_c;
	logic [ANGLE_W-1:0] resid_c;
	logic [X0_W-1:0]    x0_c;

	always_comb begin
		neg_a    = ANGLE_W'(0) - div_quo_q;
		quad_sum = neg_a + ANGLE_W'(16'h2000);
		quad_c   = quad_sum[ANGLE_W-1:ANGLE_W-2];
		resid_c  = neg_a - {quad_c, {(ANGLE_W-2){1'b0}}};
		x0_c     = X0_W'(cfg_amp_q) * X0_W'(GAIN_Q16);
	end

	// cordic micro-rotation on the shared shifter
	logic signed [CX_W-1:0] xs_c, ys_c;
	logic signed [CZ_W-1:0] at_c;

	always_comb begin
		xs_c = cx_q >>> step_q;
		ys_c = cy_q >>> step_q;
		at_c = $signed(atan_turns(ATAN_IDX_W'(step_q)));
	end

	// quadrant rotation and rounding to q1.15
	function automatic logic signed [SAMPLE_W-1:0] to_q15(input logic signed [CX_W-1:0] v);
		logic signed [CX_W:0]      s;
		logic signed [CX_W-16:0]   r;
		logic signed [SAMPLE_W-1:0] o;
		s = {v[CX_W-1], v} + (CX_W+1)'(32768);
		r = s[CX_W:16];
		if (r > (CX_W-15)'(32767)) begin
			o = 16'sh7FFF;
		end else if (r < -(CX_W-15)'(32768)) begin
			o = 16'sh8000;
		end else begin
			o = r[SAMPLE_W-1:0];
		end
		return o;
	endfunction

	logic signed [CX_W-1:0] rx_c, ry_c;

	always_comb begin
		unique case (quad_q)
			2'd1: begin
				rx_c = -cy_q;
				ry_c = cx_q;
			end
			2'd2: begin
				rx_c = -cx_q;
				ry_c = -cy_q;
			end
			2'd3: begin
				rx_c = cy_q;
				ry_c = -cx_q;
			end
			default: begin
				rx_c = cx_q;
				ry_c = cy_q;
			end
		endcase
	end

	logic out_free;
	assign out_free = !out_valid_q || rsp.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_DIV;
				end else if (dirty_q) begin
					state_d = ST_REM;
				end
			end
			ST_REM: begin
				if (step_q == STEP_W'(REM_STEPS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = ST_CORDIC;
			end
			ST_CORDIC: begin
				if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control and sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_len_q   <= RESET_LENGTH;
			cfg_root_q  <= RESET_ROOT;
			cfg_amp_q   <= RESET_AMPLITUDE;
			r2_q        <= RESET_STEP;
			dirty_q     <= 1'b0;
			n_q         <= '0;
			k_q         <= '0;
			d_q         <= RESET_STEP;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q != state_d) begin
				step_q <= '0;
			end else begin
				step_q <= step_q + STEP_W'(1);
			end

			if (accept) begin
				if (last_c) begin
					n_q <= '0;
					k_q <= '0;
					d_q <= r2_q;
				end else begin
					n_q <= n_e + LEN_W'(1);
					k_q <= k_nx;
					d_q <= d_nx;
				end
			end

			if (state_q == ST_IDLE && state_d == ST_REM) begin
				dirty_q <= 1'b0;
			end
			if (state_q == ST_REM && step_q == STEP_W'(REM_STEPS - 1)) begin
				r2_q <= {div_rem_nx[LEN_W-1:0], 1'b0};
				d_q  <= {div_rem_nx[LEN_W-1:0], 1'b0};
			end

			// length or root write restarts the sequence, step follows from the pass
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					CFG_LENGTH: begin
						cfg_len_q <= cfg.data[LEN_W-1:0];
						n_q       <= '0;
						k_q       <= '0;
						dirty_q   <= 1'b1;
					end
					CFG_ROOT: begin
						cfg_root_q <= cfg.data[LEN_W-1:0];
						n_q        <= '0;
						k_q        <= '0;
						dirty_q    <= 1'b1;
					end
					CFG_AMPLITUDE: begin
						cfg_amp_q <= cfg.data[AMP_W-1:0];
					end
					default: begin
					end
				endcase
			end

			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			div_rem_q <= k_e;
			div_src_q <= ANGLE_W'(len_eff);
			samp_q    <= n_e;
			last_q    <= last_c;
		end else if (state_q == ST_IDLE && state_d == ST_REM) begin
			div_rem_q <= '0;
			div_src_q <= {cfg_root_q, {(ANGLE_W-LEN_W){1'b0}}};
		end else if (state_q == ST_REM || state_q == ST_DIV) begin
			div_rem_q <= div_rem_nx;
			div_quo_q <= {div_quo_q[ANGLE_W-2:0], div_ge};
			div_src_q <= {div_src_q[ANGLE_W-2:0], 1'b0};
		end

		if (state_q == ST_LOAD) begin
			cx_q   <= $signed(CX_W'(x0_c));
			cy_q   <= '0;
			cz_q   <= $signed({resid_c, {(CZ_W-ANGLE_W){1'b0}}});
			quad_q <= quad_c;
		end else if (state_q == ST_CORDIC) begin
			if (!cz_q[CZ_W-1]) begin
				cx_q <= cx_q - ys_c;
				cy_q <= cy_q + xs_c;
				cz_q <= cz_q - at_c;
			end else begin
				cx_q <= cx_q + ys_c;
				cy_q <= cy_q - xs_c;
				cz_q <= cz_q + at_c;
			end
		end

		if (state_q == ST_DONE && out_free) begin
			out_i_q   <= to_q15(rx_c);
			out_q_q   <= to_q15(ry_c);
			out_n_q   <= samp_q;
			out_end_q <= last_q;
		end
	end

	assign cfg.ready         = 1'b1;
	assign req.ready         = (state_q == ST_IDLE) && !dirty_q;
	assign rsp.valid         = out_valid_q;
	assign rsp.in_phase      = out_i_q;
	assign rsp.quadrature    = out_q_q;
	assign rsp.sample_number = out_n_q;
	assign rsp.period_end    = out_end_q;

`ifndef SYNTHESIS
	// an accepted request always starts the angle divide
	a_accept_div: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q == ST_DIV)
		else $error("request beat did not start the divider");

	// the last sample of a period returns the phase to zero
	a_period_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && last_c |=> n_q == '0 && k_q == '0)
		else $error("sequence did not wrap at period end");

	// residues stay reduced whenever the phase step is current
	a_residue_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE && !dirty_q |-> k_q < mod_c && d_q < mod_c)
		else $error("phase residue out of range");
`endif

endmodule
